// ===== rtl/lrrw_pkg.sv =====
// Package for the longest replaceable run window block.
// Sizes, payload types and the count-memory write bundle; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrrw_pkg;

    localparam int MAX_STRING_LENGTH = 1024;
    localparam int ALPHABET_SIZE     = 26;

    // Field widths fixed by the channel definitions
    localparam int LETTER_W  = 5;
    localparam int CFG_W     = 11;
    localparam int BEST_W    = 11;
    localparam int OUT_LIMIT = 2047;

    // Derived sizes
    localparam int CNT_W     = $clog2(MAX_STRING_LENGTH + 1);
    localparam int HIST_AW   = $clog2(MAX_STRING_LENGTH);
    localparam int LETTER_AW = $clog2(ALPHABET_SIZE);
    localparam int SUM_W     = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    typedef logic [LETTER_W-1:0]  t_letter;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [BEST_W-1:0]    t_best;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [HIST_AW-1:0]   t_hist_addr;
    typedef logic [LETTER_AW-1:0] t_letter_addr;
    typedef logic [SUM_W-1:0]     t_sum;

    // History entry: the letter and its running occurrence count in the string
    // up to and including this position.
    typedef struct packed {
        t_letter letter;
        t_cnt    occ;
    } t_hist;

    // Updates to the count memories from the working stage
    typedef struct packed {
        logic         clear;
        logic         inc_we;
        t_letter_addr inc_letter;
        t_cnt         inc_value;
        logic         dec_we;
        t_letter_addr dec_letter;
        t_cnt         dec_value;
    } t_cnt_wr;

endpackage

`default_nettype wire

// ===== rtl/lrrw_if.sv =====
// Valid/ready channel interfaces for letters in and results out.
// Depends on lrrw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lrrw_in_if;
    import lrrw_pkg::*;

    logic    valid;
    logic    ready;
    t_letter letter_code;
    logic    starts_string;

    modport source (output valid, output letter_code, output starts_string, input ready);
    modport sink   (input valid, input letter_code, input starts_string, output ready);
endinterface

interface lrrw_out_if;
    import lrrw_pkg::*;

    logic  valid;
    logic  ready;
    t_best best_length;
    logic  overflow;

    modport source (output valid, output best_length, output overflow, input ready);
    modport sink   (input valid, input best_length, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrrw_ram.sv =====
// Generic single-clock RAM: one write port, one registered read port.
// Write-first: a read of the address being written returns the new data.
`timescale 1ns / 1ps
`default_nettype none

module lrrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/lrrw_counts.sv =====
// Per-letter counts: memories of letters entered and letters dropped,
// with a valid bit per letter that a new string clears. Depends on lrrw_pkg, lrrw_ram.
`timescale 1ns / 1ps
`default_nettype none

module lrrw_counts (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_rd_en,
    input  wire lrrw_pkg::t_letter_addr i_rd_letter,
    input  wire lrrw_pkg::t_letter_addr i_s1_letter,
    input  wire logic                   i_s1_start,
    input  wire lrrw_pkg::t_cnt_wr      i_wr,
    output lrrw_pkg::t_cnt              o_inc,
    output lrrw_pkg::t_cnt              o_dec
);
    import lrrw_pkg::*;

    logic [ALPHABET_SIZE-1:0] r_inc_v;
    logic [ALPHABET_SIZE-1:0] r_dec_v;
    logic [ALPHABET_SIZE-1:0] n_inc_v;
    logic [ALPHABET_SIZE-1:0] n_dec_v;
    t_cnt                     inc_rdata;
    t_cnt                     dec_rdata;

    lrrw_ram #(
        .WIDTH (CNT_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_inc_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.inc_we),
        .i_waddr (i_wr.inc_letter),
        .i_wdata (i_wr.inc_value),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_letter),
        .o_rdata (inc_rdata)
    );

    lrrw_ram #(
        .WIDTH (CNT_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_dec_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.dec_we),
        .i_waddr (i_wr.dec_letter),
        .i_wdata (i_wr.dec_value),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_letter),
        .o_rdata (dec_rdata)
    );

    always_comb begin
        n_inc_v = i_wr.clear ? '0 : r_inc_v;
        n_dec_v = i_wr.clear ? '0 : r_dec_v;
        if (i_wr.inc_we) begin
            n_inc_v[i_wr.inc_letter] = 1'b1;
        end
        if (i_wr.dec_we) begin
            n_dec_v[i_wr.dec_letter] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc_v <= '0;
            r_dec_v <= '0;
        end else begin
            r_inc_v <= n_inc_v;
            r_dec_v <= n_dec_v;
        end
    end

    // Entries not written in this string read as zero
    assign o_inc = (!i_s1_start && r_inc_v[i_s1_letter]) ? inc_rdata : '0;
    assign o_dec = (!i_s1_start && r_dec_v[i_s1_letter]) ? dec_rdata : '0;

    // A letter's drop count is never valid without its entry count
    a_dec_le_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dec_v & ~r_inc_v) == '0)
        else $error("dec count valid without inc count");

endmodule

`default_nettype wire

// ===== rtl/longest_replaceable_run_window.sv =====
// Longest replaceable run window: top level.
// Depends on lrrw_pkg, lrrw_if, lrrw_ram, lrrw_counts.
//
// Letters arrive on i_in (valid/ready), one per transaction, A=0 .. Z=25;
// starts_string clears the string state before its letter. Every input
// transaction yields one result transaction on o_out: the longest window so far
// in which up to max_replacements letters could be replaced to make one run,
// and a sticky overflow flag once the string outgrows the history memory
// (later letters are then ignored). Codes outside the alphabet change nothing
// but still give a result.
// max_replacements is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while idle, which the block itself does not enforce. A letter
// passes the working stage, then the result register. Throughput: one letter
// per cycle unless o_out stalls; set by the read-modify-write of the count
// memories, whose write-first read port forwards the previous letter's update.
// Reset is synchronous and leaves no clearing pass: per-letter valid bits mark
// written counts, and the history memory is only read where already written.
// When o_out stalls, the result register holds, the working stage holds one
// letter, and i_in.ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module longest_replaceable_run_window (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire lrrw_pkg::t_cfg i_cfg_wdata,
    lrrw_in_if.sink             i_in,
    lrrw_out_if.source          o_out
);
    import lrrw_pkg::*;

    t_cfg       r_max_repl;

    // working stage
    logic       r_s1_valid;
    t_letter    r_s1_code;
    logic       r_s1_start;

    // string state
    t_cnt       r_wp;
    t_cnt       r_wl;
    t_cnt       r_top;
    t_hist_addr r_oldest;
    logic       r_ovf;
    t_cnt       n_wp;
    t_cnt       n_wl;
    t_cnt       n_top;
    t_hist_addr n_oldest;
    logic       n_ovf;

    // result register
    logic       r_out_valid;
    t_best      r_best;
    logic       r_out_ovf;

    logic       s1_fire;
    logic       in_ready;
    logic       accept;

    t_cnt       inc_e;
    t_cnt       dec_e;
    t_hist      hist_rd;
    t_hist      hist_wd;
    logic       hist_we;
    t_hist_addr hist_waddr;
    t_cnt_wr    cnt_wr;

    t_cnt       wp_e;
    t_cnt       wl_e;
    t_cnt       top_e;
    t_hist_addr old_e;
    logic       ovf_e;
    logic       in_alpha;
    logic       full;
    logic       take;
    logic       drop;
    t_cnt       inc_new;
    t_cnt       cnt_new;
    t_cnt       top_new;
    t_sum       limit;

    assign s1_fire  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_s1_valid || s1_fire;
    assign accept   = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    always_comb begin
        wp_e  = r_s1_start ? '0 : r_wp;
        wl_e  = r_s1_start ? '0 : r_wl;
        top_e = r_s1_start ? '0 : r_top;
        old_e = r_s1_start ? '0 : r_oldest;
        ovf_e = r_s1_start ? 1'b0 : r_ovf;

        in_alpha = 32'(r_s1_code) < ALPHABET_SIZE;
        full     = 32'(wp_e) >= MAX_STRING_LENGTH;
        take     = in_alpha && !full;

        inc_new = inc_e + 1'b1;
        cnt_new = inc_new - dec_e;
        top_new = (take && (cnt_new > top_e)) ? cnt_new : top_e;

        // (wl + 1) - top > R  <=>  wl >= top + R
        limit = SUM_W'(top_new) + SUM_W'(r_max_repl);
        drop  = take && (SUM_W'(wl_e) >= limit);
    end

    // Window never shrinks, so best length equals window length
    always_comb begin
        n_wp     = r_wp;
        n_wl     = r_wl;
        n_top    = r_top;
        n_oldest = r_oldest;
        n_ovf    = r_ovf;
        if (s1_fire) begin
            n_wp     = take ? (wp_e + 1'b1) : wp_e;
            n_wl     = (take && !drop) ? (wl_e + 1'b1) : wl_e;
            n_top    = top_new;
            n_oldest = drop ? (old_e + 1'b1) : old_e;
            n_ovf    = ovf_e || (in_alpha && full);
        end
    end

    always_comb begin
        hist_we        = s1_fire && take;
        hist_waddr     = HIST_AW'(wp_e);
        hist_wd.letter = r_s1_code;
        hist_wd.occ    = inc_new;

        cnt_wr.clear      = s1_fire && r_s1_start;
        cnt_wr.inc_we     = s1_fire && take;
        cnt_wr.inc_letter = LETTER_AW'(r_s1_code);
        cnt_wr.inc_value  = inc_new;
        // dropped letter's count of drops becomes its occurrence number
        cnt_wr.dec_we     = s1_fire && drop;
        cnt_wr.dec_letter = LETTER_AW'(hist_rd.letter);
        cnt_wr.dec_value  = hist_rd.occ;
    end

    // History read for the next letter targets the oldest entry after this one
    lrrw_ram #(
        .WIDTH ($bits(t_hist)),
        .DEPTH (MAX_STRING_LENGTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wd),
        .i_re    (accept),
        .i_raddr (n_oldest),
        .o_rdata (hist_rd)
    );

    lrrw_counts u_counts (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_letter (LETTER_AW'(i_in.letter_code)),
        .i_s1_letter (LETTER_AW'(r_s1_code)),
        .i_s1_start  (r_s1_start),
        .i_wr        (cnt_wr),
        .o_inc       (inc_e),
        .o_dec       (dec_e)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_repl <= '0;
        end else if (i_cfg_we) begin
            r_max_repl <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wp        <= '0;
            r_wl        <= '0;
            r_top       <= '0;
            r_oldest    <= '0;
            r_ovf       <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_wp     <= n_wp;
            r_wl     <= n_wl;
            r_top    <= n_top;
            r_oldest <= n_oldest;
            r_ovf    <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_code  <= i_in.letter_code;
            r_s1_start <= i_in.starts_string;
        end
        if (s1_fire) begin
            r_best    <= (32'(n_wl) > OUT_LIMIT) ? BEST_W'(OUT_LIMIT) : BEST_W'(n_wl);
            r_out_ovf <= n_ovf;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.best_length = r_best;
    assign o_out.overflow    = r_out_ovf;

    a_wl_le_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wl <= r_wp)
        else $error("window longer than string");

    a_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_wl) == CNT_W'(r_oldest))
        else $error("oldest pointer out of step with window");

    a_top_le_wl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= r_wl)
        else $error("top count above window length");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_valid)
        else $error("working stage fired without a result");

endmodule

`default_nettype wire

// ===== verif/tb_longest_replaceable_run_window.sv =====
// Testbench for longest_replaceable_run_window: directed table, then random strings.
// Each result is checked against the bench's window predictor or a typed row.
// Depends on lrrw_pkg, lrrw_if and the block's RTL.
`timescale 1ns / 1ps

module tb_longest_replaceable_run_window;
    import lrrw_pkg::*;

    typedef struct {
        t_best best_length;
        logic  overflow;
    } t_window_result;

    typedef struct {
        logic    load_limit;
        t_cfg    limit;
        t_letter code;
        logic    fresh;
        logic    typed;
        t_best   want_best;
        logic    want_ovf;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    t_cfg cfg_wdata;

    lrrw_in_if  in_ch ();
    lrrw_out_if out_ch ();

    longest_replaceable_run_window dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Window predictor state
    int   limit_reg;
    int   ring_letters [MAX_STRING_LENGTH];
    int   letter_tally [ALPHABET_SIZE];
    int   peak_tally;
    int   span;
    int   fill;
    int   longest;
    logic too_long;

    t_window_result pending_results [$];
    t_stim_row      directed [$];

    int   fail_count;
    int   letters_sent;
    int   strings_begun;
    int   limits_loaded;
    int   overflow_results;
    logic quiet_mode;

    function automatic void clear_window();
        foreach (letter_tally[k]) letter_tally[k] = 0;
        peak_tally = 0;
        span       = 0;
        fill       = 0;
        longest    = 0;
        too_long   = 1'b0;
    endfunction

    function automatic void advance_window(input t_letter code, input logic fresh,
                                           output t_best best, output logic ovf);
        int gone;
        if (fresh)
            clear_window();
        if (int'(code) < ALPHABET_SIZE) begin
            if (fill >= MAX_STRING_LENGTH) begin
                too_long = 1'b1;
            end else begin
                ring_letters[fill] = int'(code);
                fill++;
                letter_tally[code]++;
                if (letter_tally[code] > peak_tally)
                    peak_tally = letter_tally[code];
                span++;
                // peak is never lowered, so the window slides rather than shrinks
                if (span > peak_tally && span - peak_tally > limit_reg) begin
                    gone = ring_letters[fill - span];
                    if (letter_tally[gone] > 0)
                        letter_tally[gone]--;
                    span--;
                end
                if (span > longest)
                    longest = span;
            end
        end
        best = (longest > OUT_LIMIT) ? t_best'(OUT_LIMIT) : t_best'(longest);
        ovf  = too_long;
    endfunction

    function automatic int draw_wait();
        return quiet_mode ? 0 : int'($urandom_range(0, 19));
    endfunction

    task automatic add_row(input int load_limit, input int limit, input int code,
                           input int fresh, input int typed, input int want_best,
                           input int want_ovf);
        t_stim_row row;
        row.load_limit = 1'(load_limit);
        row.limit      = t_cfg'(limit);
        row.code       = t_letter'(code);
        row.fresh      = 1'(fresh);
        row.typed      = 1'(typed);
        row.want_best  = t_best'(want_best);
        row.want_ovf   = 1'(want_ovf);
        directed.push_back(row);
    endtask

    task automatic send_letter(input t_letter code, input logic fresh, input logic typed,
                               input t_best want_best, input logic want_ovf);
        int             gap;
        t_best          best;
        logic           ovf;
        t_window_result res;
        gap = draw_wait();
        repeat (gap) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid         <= 1'b1;
        in_ch.letter_code   <= code;
        in_ch.starts_string <= fresh;
        do @(posedge clk); while (!in_ch.ready);
        advance_window(code, fresh, best, ovf);
        if (typed) begin
            best = want_best;
            ovf  = want_ovf;
        end
        res.best_length = best;
        res.overflow    = ovf;
        pending_results.push_back(res);
        letters_sent++;
        if (fresh)
            strings_begun++;
    endtask

    // Stop sending and wait until every outstanding result has been taken
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_limit(input t_cfg value);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        limit_reg  = int'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        limits_loaded++;
    endtask

    // Result side: random stalls, compare each transaction with the oldest expectation
    initial begin
        int             stall;
        t_window_result want;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = draw_wait();
            repeat (stall) begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            if (pending_results.size() == 0) begin
                $error("unexpected result: best_length %0d overflow %0d",
                       out_ch.best_length, out_ch.overflow);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.best_length !== want.best_length) begin
                    $error("best_length mismatch: expected %0d, got %0d",
                           want.best_length, out_ch.best_length);
                    fail_count++;
                end
                if (out_ch.overflow !== want.overflow) begin
                    $error("overflow mismatch: expected %0d, got %0d",
                           want.overflow, out_ch.overflow);
                    fail_count++;
                end
                if (want.overflow)
                    overflow_results++;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_stim_row row;
        t_letter   code;
        logic      fresh;
        int        phase;
        int        len;
        int        base;
        int        spread;
        t_cfg      limit;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        in_ch.valid         = 1'b0;
        in_ch.letter_code   = '0;
        in_ch.starts_string = 1'b0;
        quiet_mode          = 1'b0;
        fail_count          = 0;
        letters_sent        = 0;
        strings_begun       = 0;
        limits_loaded       = 0;
        overflow_results    = 0;
        limit_reg           = 0;
        clear_window();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // limit 0 after reset: window grows only on repeats
        add_row(0, 0,     0, 1, 1, 1, 0);
        add_row(0, 0,     0, 0, 1, 2, 0);
        add_row(0, 0,    25, 0, 1, 2, 0);
        add_row(0, 0,    31, 0, 1, 2, 0);   // out of alphabet, nothing changes
        add_row(0, 0,    26, 1, 1, 0, 0);   // clear with no letter taken
        add_row(0, 0,    25, 0, 1, 1, 0);
        // widest limit: every letter joins the window
        add_row(1, 2047,  1, 1, 0, 0, 0);
        add_row(0, 0,     2, 0, 0, 0, 0);
        add_row(0, 0,     4, 0, 0, 0, 0);
        add_row(0, 0,     8, 0, 0, 0, 0);
        add_row(0, 0,    16, 0, 0, 0, 0);
        // one replacement over AABABBA
        add_row(1, 1,     0, 1, 0, 0, 0);
        add_row(0, 0,     0, 0, 0, 0, 0);
        add_row(0, 0,     1, 0, 0, 0, 0);
        add_row(0, 0,     0, 0, 0, 0, 0);
        add_row(0, 0,     1, 0, 0, 0, 0);
        add_row(0, 0,     1, 0, 0, 0, 0);
        add_row(0, 0,     0, 0, 0, 0, 0);
        // alternating letters: peak count stays put while the window slides
        add_row(1, 0,     0, 1, 0, 0, 0);
        add_row(0, 0,     1, 0, 0, 0, 0);
        add_row(0, 0,     0, 0, 0, 0, 0);
        add_row(0, 0,     1, 0, 0, 0, 0);
        add_row(0, 0,     2, 0, 0, 0, 0);
        add_row(1, 1024, 30, 1, 0, 0, 0);
        add_row(0, 0,    24, 0, 0, 0, 0);

        for (int r = 0; r < directed.size(); r++) begin
            row = directed[r];
            if (row.load_limit)
                load_limit(row.limit);
            send_letter(row.code, row.fresh, row.typed, row.want_best, row.want_ovf);
        end

        phase = 0;
        while (letters_sent < 1750) begin
            case ($urandom_range(0, 6))
                0: limit = t_cfg'(0);
                1: limit = t_cfg'(1);
                2: limit = t_cfg'(2);
                3: limit = t_cfg'(1024);
                4: limit = t_cfg'(2047);
                5: limit = t_cfg'($urandom_range(0, 2047));
                default: limit = t_cfg'($urandom_range(3, 12));
            endcase
            load_limit(limit);
            quiet_mode = (phase % 3 == 1);
            if (phase == 2) begin
                // one string past the history depth, few letters so windows get long
                base = int'($urandom_range(0, 24));
                for (int i = 0; i < MAX_STRING_LENGTH + 16; i++) begin
                    if (i == MAX_STRING_LENGTH / 2)
                        settle();
                    code = t_letter'(base + int'($urandom_range(0, 1)));
                    send_letter(code, i == 0, 1'b0, '0, 1'b0);
                end
            end else begin
                for (int s = 0; s < 8; s++) begin
                    len    = int'($urandom_range(1, 40));
                    base   = int'($urandom_range(0, 22));
                    spread = int'($urandom_range(1, 4));
                    if ($urandom_range(0, 9) == 0) begin
                        base   = 0;
                        spread = ALPHABET_SIZE;
                    end
                    for (int i = 0; i < len; i++) begin
                        code  = t_letter'(base + int'($urandom_range(0, spread - 1)));
                        fresh = (i == 0) || ($urandom_range(0, 49) == 0);
                        if ($urandom_range(0, 19) == 0)
                            code = t_letter'($urandom_range(0, 31));
                        send_letter(code, fresh, 1'b0, '0, 1'b0);
                    end
                end
            end
            phase++;
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Covered %0d letters in %0d strings under %0d replacement limits;",
                 letters_sent, strings_begun, limits_loaded);
        $display("%0d results carried the overflow flag.", overflow_results);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
